// ===== hdl/bga_pkg.sv =====
// bga_pkg: shared types and constants of the baseline gain apply block
// used by bga_front, bga_back and the top level; no dependencies
`default_nettype none

package bga_pkg;

   // item kind carried on the request tuser
   localparam logic KIND_GAIN = 1'b0;
   localparam logic KIND_VIS  = 1'b1;

   // sample and gain widths, gain fraction bits
   localparam int DATA_W    = 16;
   localparam int GAIN_FRAC = 12;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // control flags of one queued word
   typedef struct packed {
      logic is_vis;    // visibility sample, else gain write
      logic store_ok;  // gain write hits the table
      logic last;      // final baseline of the walk
   } bga_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/bga_ram.sv =====
// bga_ram: generic single write port, single read port ram, registered read
// no dependencies
`default_nettype none

module bga_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bga_fifo.sv =====
// bga_fifo: small register queue between the front and the back part
// no dependencies; depth must be a power of two
`default_nettype none

module bga_fifo #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

`ifndef SYNTHESIS
   // fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue fill count above depth");
`endif

endmodule

`default_nettype wire

// ===== hdl/bga_front.sv =====
// bga_front: takes request words, holds the station count and the baseline walk,
// tags each word with its baseline and pushes it to the queue; uses bga_pkg
`default_nettype none

module bga_front #(
   parameter int MAX_STATIONS = 256,
   parameter int ENTRY_W      = 67
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [39:0]        req_tdata,
   input  wire logic [0:0]         req_tuser,
   // station count write
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [8:0]         csr_data,
   // queue push side
   output logic                    push_valid,
   input  wire logic               push_ready,
   output logic      [ENTRY_W-1:0] push_data
);

   localparam int AW     = $clog2(MAX_STATIONS);
   localparam int CNT_W  = $clog2(MAX_STATIONS + 1);
   localparam int WIDE_W = (CNT_W > 9) ? CNT_W : 9;
   localparam int IW     = (CNT_W > 8) ? CNT_W : 8;

   logic [8:0]        count_ff;
   logic [CNT_W-1:0]  row_ff, col_ff, row_in, col_in;
   logic [WIDE_W-1:0] count_wide, n_wide;
   logic [CNT_W-1:0]  n, p, q;
   logic [IW-1:0]     p_ext, q_ext, idx_ext;
   logic              accept, is_vis, restart, last, store_ok;
   logic [AW-1:0]     addr_p, addr_q;
   bga_pkg::bga_ctl_type ctl;

   assign csr_ready  = 1'b1;
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;
   assign is_vis     = (req_tuser[0] == bga_pkg::KIND_VIS);

   // effective station count, clamped to two and the table depth
   always_comb begin
      count_wide = WIDE_W'(count_ff);
      if (count_wide < WIDE_W'(2)) begin
         n_wide = WIDE_W'(2);
      end else if (count_wide > WIDE_W'(MAX_STATIONS)) begin
         n_wide = WIDE_W'(MAX_STATIONS);
      end else begin
         n_wide = count_wide;
      end
      n = n_wide[CNT_W-1:0];
   end

   // current baseline, restarting when the walk lies outside the count
   always_comb begin
      restart = (col_ff >= n) || (row_ff >= col_ff);
      p       = restart ? '0 : row_ff;
      q       = restart ? CNT_W'(1) : col_ff;
      last    = (p == n - CNT_W'(2)) && (q == n - CNT_W'(1));
   end

   // next walk position
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (!is_vis || last) begin
            row_in = '0;
            col_in = CNT_W'(1);
         end else if ((q + CNT_W'(1)) < n) begin
            row_in = p;
            col_in = q + CNT_W'(1);
         end else begin
            row_in = p + CNT_W'(1);
            col_in = p + CNT_W'(2);
         end
      end
   end

   // queue word: control, table addresses, tag stations, data
   always_comb begin
      idx_ext      = IW'(req_tdata[7:0]);
      store_ok     = (idx_ext < IW'(MAX_STATIONS));
      p_ext        = IW'(p);
      q_ext        = IW'(q);
      addr_p       = is_vis ? p[AW-1:0] : idx_ext[AW-1:0];
      addr_q       = q[AW-1:0];
      ctl.is_vis   = is_vis;
      ctl.store_ok = store_ok;
      ctl.last     = last;
      push_data    = {ctl, addr_p, addr_q, p_ext[7:0], q_ext[7:0],
                      req_tdata[23:8], req_tdata[39:24]};
   end

   // station count register and walk counters
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 9'd2;
         row_ff   <= '0;
         col_ff   <= CNT_W'(1);
      end else begin
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

`ifndef SYNTHESIS
   // walk always stays in the upper triangle
   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      row_ff < col_ff)
      else $error("baseline walk left the upper triangle");
`endif

endmodule

`default_nettype wire

// ===== hdl/bga_back.sv =====
// bga_back: pops queued words, writes gains to the tables and applies
// v*gp*conj(gq) to visibilities; uses bga_pkg and bga_ram
`default_nettype none

module bga_back #(
   parameter int MAX_STATIONS = 256,
   parameter int ENTRY_W      = 67
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // queue pop side
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   input  wire logic [ENTRY_W-1:0] pop_data,
   // result channel
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic      [47:0]        rsp_tdata,
   output logic                    rsp_tlast,
   output logic      [0:0]         rsp_tuser
);

   localparam int AW    = $clog2(MAX_STATIONS);
   localparam int CTL_W = $bits(bga_pkg::bga_ctl_type);
   localparam int DW    = bga_pkg::DATA_W;
   localparam int FR    = bga_pkg::GAIN_FRAC;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL1,
      S_SUM1,
      S_MUL2,
      S_SUM2
   } state_type;

   state_type state_ff;

   // unpacked queue word
   bga_pkg::bga_ctl_type   e_ctl;
   logic [AW-1:0]          e_addr_p, e_addr_q;
   logic [7:0]             e_row, e_col;
   logic signed [DW-1:0]   e_re, e_im;

   // gain tables, one copy per read address
   logic                   ram_we, ram_re;
   logic [2*DW-1:0]        gp_data, gq_data;
   logic signed [DW-1:0]   gpr, gpi, gqr, gqi;

   // datapath
   logic signed [DW-1:0]   vr_ff, vi_ff;
   logic [7:0]             row_ff, col_ff;
   logic                   last_ff;
   logic signed [2*DW-1:0] m1_0_ff, m1_1_ff, m1_2_ff, m1_3_ff;
   logic signed [2*DW-1:0] m1_0_in, m1_1_in, m1_2_in, m1_3_in;
   logic signed [2*DW:0]   a_full, b_full;
   logic signed [2*DW-FR:0] a_ff, b_ff, a_in, b_in;
   logic signed [3*DW-FR:0] m2_0_ff, m2_1_ff, m2_2_ff, m2_3_ff;
   logic signed [3*DW-FR:0] m2_0_in, m2_1_in, m2_2_in, m2_3_in;
   logic signed [3*DW-FR+1:0] r_full, i_full;
   logic signed [3*DW-2*FR+1:0] r_shift, i_shift;
   logic signed [DW-1:0]   r_sat, i_sat;
   logic                   r_clip, i_clip, out_free;

   // result register
   logic                   rsp_valid_ff;
   logic [47:0]            rsp_data_ff;
   logic                   rsp_last_ff, rsp_clip_ff;

   assign e_im     = pop_data[DW-1:0];
   assign e_re     = pop_data[2*DW-1:DW];
   assign e_col    = pop_data[2*DW+7:2*DW];
   assign e_row    = pop_data[2*DW+15:2*DW+8];
   assign e_addr_q = pop_data[2*DW+16 +: AW];
   assign e_addr_p = pop_data[2*DW+16+AW +: AW];
   assign e_ctl    = bga_pkg::bga_ctl_type'(pop_data[ENTRY_W-1 -: CTL_W]);

   // pop and table access only from idle
   assign pop_ready = (state_ff == S_IDLE);
   assign ram_we    = pop_valid && pop_ready && !e_ctl.is_vis && e_ctl.store_ok;
   assign ram_re    = pop_valid && pop_ready && e_ctl.is_vis;

   bga_ram #(.WIDTH(2*DW), .DEPTH(MAX_STATIONS)) u_ram_p (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (e_addr_p),
      .wr_data ({e_im, e_re}),
      .rd_en   (ram_re),
      .rd_addr (e_addr_p),
      .rd_data (gp_data)
   );

   bga_ram #(.WIDTH(2*DW), .DEPTH(MAX_STATIONS)) u_ram_q (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (e_addr_p),
      .wr_data ({e_im, e_re}),
      .rd_en   (ram_re),
      .rd_addr (e_addr_q),
      .rd_data (gq_data)
   );

   assign gpr = gp_data[DW-1:0];
   assign gpi = gp_data[2*DW-1:DW];
   assign gqr = gq_data[DW-1:0];
   assign gqi = gq_data[2*DW-1:DW];

   // first complex product, v * gp
   always_comb begin
      m1_0_in = vr_ff * gpr;
      m1_1_in = vi_ff * gpi;
      m1_2_in = vi_ff * gpr;
      m1_3_in = vr_ff * gpi;
   end

   // sums of the first product, floor shift
   always_comb begin
      a_full = (2*DW+1)'(m1_0_ff) - (2*DW+1)'(m1_1_ff);
      b_full = (2*DW+1)'(m1_2_ff) + (2*DW+1)'(m1_3_ff);
      a_in   = a_full[2*DW:FR];
      b_in   = b_full[2*DW:FR];
   end

   // second complex product, times conj(gq)
   always_comb begin
      m2_0_in = a_ff * gqr;
      m2_1_in = b_ff * gqi;
      m2_2_in = b_ff * gqr;
      m2_3_in = a_ff * gqi;
   end

   // final sums, floor shift and saturation
   always_comb begin
      r_full  = (3*DW-FR+2)'(m2_0_ff) + (3*DW-FR+2)'(m2_1_ff);
      i_full  = (3*DW-FR+2)'(m2_2_ff) - (3*DW-FR+2)'(m2_3_ff);
      r_shift = r_full[3*DW-FR+1:FR];
      i_shift = i_full[3*DW-FR+1:FR];
      r_clip  = 1'b1;
      i_clip  = 1'b1;
      if (r_shift > (3*DW-2*FR+2)'(32767)) begin
         r_sat = 16'sh7FFF;
      end else if (r_shift < -(3*DW-2*FR+2)'(32768)) begin
         r_sat = -16'sh8000;
      end else begin
         r_sat  = r_shift[DW-1:0];
         r_clip = 1'b0;
      end
      if (i_shift > (3*DW-2*FR+2)'(32767)) begin
         i_sat = 16'sh7FFF;
      end else if (i_shift < -(3*DW-2*FR+2)'(32768)) begin
         i_sat = -16'sh8000;
      end else begin
         i_sat  = i_shift[DW-1:0];
         i_clip = 1'b0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer, datapath registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in the final step the result register is reloaded instead
         if (rsp_valid_ff && rsp_tready && (state_ff != S_SUM2)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (ram_re) begin
                  vr_ff    <= e_re;
                  vi_ff    <= e_im;
                  row_ff   <= e_row;
                  col_ff   <= e_col;
                  last_ff  <= e_ctl.last;
                  state_ff <= S_MUL1;
               end
            end
            S_MUL1: begin
               m1_0_ff  <= m1_0_in;
               m1_1_ff  <= m1_1_in;
               m1_2_ff  <= m1_2_in;
               m1_3_ff  <= m1_3_in;
               state_ff <= S_SUM1;
            end
            S_SUM1: begin
               a_ff     <= a_in;
               b_ff     <= b_in;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               m2_0_ff  <= m2_0_in;
               m2_1_ff  <= m2_1_in;
               m2_2_ff  <= m2_2_in;
               m2_3_ff  <= m2_3_in;
               state_ff <= S_SUM2;
            end
            S_SUM2: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {col_ff, row_ff, i_sat, r_sat};
                  rsp_last_ff  <= last_ff;
                  rsp_clip_ff  <= r_clip || i_clip;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_clip_ff;

`ifndef SYNTHESIS
   // a table write and a table read never share a cycle
   a_ram_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("gain table written and read in one cycle");

   // a new result only comes out of the final sum step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_SUM2))
      else $error("result raised outside the final step");

   // the sequencer leaves idle only for a visibility
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !ram_re) |=> (state_ff == S_IDLE))
      else $error("sequencer started without a visibility");
`endif

endmodule

`default_nettype wire

// ===== hdl/baseline_gain_apply_top.sv =====
// baseline_gain_apply_top: per-baseline complex gain correction of visibilities
// depends on bga_pkg, bga_front, bga_fifo, bga_back, bga_ram
//
// Usage
//   req channel: each word is a gain write (tuser = 0) or a visibility (tuser = 1).
//   A gain write stores station_index's Q4.12 gain and restarts the baseline
//   walk at (0,1); it gives no result. Visibilities come in upper-triangle order
//   and each gives one rsp word: v*gp*conj(gq), saturated to 16 bits, tagged
//   with p, q, tlast on the final baseline and tuser set when saturated.
//   csr channel writes the station count; write it only while the block is idle.
//   Gains must be written before any visibility uses them.
// Timing
//   A visibility's result is registered once the back part has gone through
//   MUL1, SUM1, MUL2 and SUM2 and the result register is free. The back sequencer
//   holds one visibility at a time through its two multiply stages; gain writes
//   retire at one per cycle while it is idle. A 4-word queue in front lets
//   requests be taken while the back part works or waits.
// Reset and stalls
//   Reset clears the queue, the result register and the walk (back to (0,1));
//   the station count returns to 2 and reset leaves the gain tables untouched.
//   When rsp_tready is low the result word holds, the back part waits, and
//   req_tready drops once the queue is full.
`default_nettype none

module baseline_gain_apply_top #(
   parameter int MAX_STATIONS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tdata = station_index[7:0], in_real[23:8], in_imag[39:24]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   // request: tuser = req_type[0]
   input  wire logic [0:0]  req_tuser,
   // result: tdata = out_real[15:0], out_imag[31:16], row_station[39:32],
   //         col_station[47:40]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata,
   output logic             rsp_tlast,
   // result: tuser = clipped[0]
   output logic      [0:0]  rsp_tuser,
   // station count write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [8:0]  csr_data
);

   localparam int AW      = $clog2(MAX_STATIONS);
   localparam int ENTRY_W = $bits(bga_pkg::bga_ctl_type) + 2*AW + 16
                            + 2*bga_pkg::DATA_W;

   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   // front: accept, walk, tag
   bga_front #(.MAX_STATIONS(MAX_STATIONS), .ENTRY_W(ENTRY_W)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // queue between front and back
   bga_fifo #(.WIDTH(ENTRY_W), .DEPTH(bga_pkg::QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: gain tables and correction datapath
   bga_back #(.MAX_STATIONS(MAX_STATIONS), .ENTRY_W(ENTRY_W)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
